@@ src/hsc_pkg.sv @@
// hsc_pkg: shared types and constants for the hsv sky classifier
// no dependencies
package hsc_pkg;
  localparam int CountWidth = 17;
  localparam int NumRegs = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegBlueLow = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBlueHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBrightLow = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBrightHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlueThr = 3'd4;
  localparam logic [CfgIdxW-1:0] RegClearLvl = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDarkLvl = 3'd6;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd7;

  localparam logic [1:0] ClsClear = 2'd0;
  localparam logic [1:0] ClsPartly = 2'd1;
  localparam logic [1:0] ClsDark = 2'd2;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } bgr_t;

  // one stage of the conversion chain
  typedef struct packed {
    logic        vld;
    logic        last;
    logic [7:0]  v;
    logic [7:0]  diff;
    logic [11:0] hnum;   // signed numerator, offset form
    logic [1:0]  sect;
    logic [19:0] sf;
    logic [17:0] hf;
    logic [7:0]  s;
    logic [7:0]  h;
  } cell_t;

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        blue_hit;
    logic        bright_hit;
  } hit_t;
endpackage

@@ src/hsc_if.sv @@
// hsc_stream_if: valid/ready channel with a generic payload
// depends on nothing
interface hsc_stream_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/hsc_cell.sv @@
// hsc_cell: one step of the hsv conversion chain
// depends on hsc_pkg
module hsc_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [1:0]     step,
  input  hsc_pkg::bgr_t  pix,
  input  hsc_pkg::cell_t prev,
  output hsc_pkg::cell_t cur_r
);
  hsc_pkg::cell_t nxt;
  logic [7:0] mx, mn;
  logic signed [11:0] hs;
  logic signed [21:0] x;
  logic [20:0] sprod;
  logic [19:0] sf_tab [256];
  logic [17:0] hf_tab [256];

  // rounded reciprocal tables, constant per entry
  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam logic [19:0] SfQ = 20'((i == 0) ? 0 : (255 * 8192 + i) / (2 * i));
    localparam logic [17:0] HfQ = 18'((i == 0) ? 0 : (245760 + i) / (2 * i));
    assign sf_tab[i] = SfQ;
    assign hf_tab[i] = HfQ;
  end

  always_comb begin
    nxt = prev;
    mx = 8'd0; mn = 8'd0; hs = '0; x = '0; sprod = '0;
    case (step)
      2'd0: begin
        mx = pix.b; mn = pix.b;
        if (pix.g > mx) mx = pix.g;
        if (pix.r > mx) mx = pix.r;
        if (pix.g < mn) mn = pix.g;
        if (pix.r < mn) mn = pix.r;
        nxt.v = mx;
        nxt.diff = mx - mn;
        if (mx == pix.r) begin
          nxt.sect = 2'd0;
          hs = $signed({4'b0, pix.g}) - $signed({4'b0, pix.b});
        end else if (mx == pix.g) begin
          nxt.sect = 2'd1;
          hs = $signed({4'b0, pix.b}) - $signed({4'b0, pix.r})
             + $signed({3'b0, mx - mn, 1'b0});
        end else begin
          nxt.sect = 2'd2;
          hs = $signed({4'b0, pix.r}) - $signed({4'b0, pix.g})
             + $signed({2'b0, mx - mn, 2'b0});
        end
        nxt.hnum = hs;
      end
      2'd1: begin
        nxt.sf = sf_tab[prev.v];
        nxt.hf = hf_tab[prev.diff];
      end
      2'd2: begin
        sprod = prev.diff * prev.sf + 21'd2048;
        nxt.s = (prev.v == 8'd0) ? 8'd0 : sprod[19:12];
        x = $signed(prev.hnum) * $signed({1'b0, prev.hf}) + 22'sd2048 + 22'sd1048576;
        hs = $signed({3'b0, x[20:12]}) - 12'sd256;
        if (hs < 0) hs = hs + 12'sd180;
        nxt.h = (prev.diff == 8'd0) ? 8'd0 : hs[7:0];
      end
      default: nxt = prev;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) cur_r.vld <= 1'b0;
    else if (en) cur_r.vld <= prev.vld;
    if (en) begin
      cur_r.last <= nxt.last; cur_r.v <= nxt.v; cur_r.diff <= nxt.diff;
      cur_r.hnum <= nxt.hnum; cur_r.sect <= nxt.sect; cur_r.sf <= nxt.sf;
      cur_r.hf <= nxt.hf; cur_r.s <= nxt.s; cur_r.h <= nxt.h;
    end
  end
endmodule

@@ src/hsc_match.sv @@
// hsc_match: box test cell after the conversion chain
// depends on hsc_pkg
module hsc_match (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  hsc_pkg::cell_t prev,
  input  logic [23:0]    blue_lo,
  input  logic [23:0]    blue_hi,
  input  logic [23:0]    brt_lo,
  input  logic [23:0]    brt_hi,
  output hsc_pkg::hit_t  hit_r
);
  logic [23:0] p;
  function automatic logic in_box(input logic [23:0] q, input logic [23:0] lo,
                                  input logic [23:0] hi);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 3; k++)
      if (q[k*8+:8] < lo[k*8+:8] || q[k*8+:8] > hi[k*8+:8]) ok = 1'b0;
    return ok;
  endfunction
  assign p = {prev.h, prev.s, prev.v};
  always_ff @(posedge clk) begin
    if (!rst_n) hit_r.vld <= 1'b0;
    else if (en) hit_r.vld <= prev.vld;
    if (en) begin
      hit_r.last <= prev.last;
      hit_r.blue_hit <= in_box(p, blue_lo, blue_hi);
      hit_r.bright_hit <= in_box(p, brt_lo, brt_hi);
    end
  end
endmodule

@@ src/hsv_pixel_count_sky_classifier.sv @@
// hsv_pixel_count_sky_classifier: top level of the hsv sky classifier
// depends on hsc_pkg, hsc_stream_if, hsc_cell, hsc_match
//
// usage: pixels enter on the in channel as {blue, green, red, frame_end};
// one result per frame leaves on the out channel when frame_end is set.
// cfg_we writes register cfg_idx with cfg_data; the user must write only
// while idle, the block does not enforce it. each pixel walks a chain of
// three conversion cells (min/max and hue numerator, reciprocal lookup,
// multiply and round) and one box test cell, then updates the saturating
// counters; a pixel is accepted every cycle unless the chain is stalled.
// the whole chain advances only when the output register is empty or being
// taken, so a stalled receiver holds the chain and drops in_ready.
// reset clears counters, report phase, valid bits and restores register
// defaults; no clearing pass is needed.
module hsv_pixel_count_sky_classifier (
  input  logic clk,
  input  logic rst_n,
  hsc_stream_if.sink   in_ch,
  hsc_stream_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [hsc_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [hsc_pkg::CfgDataW-1:0]  cfg_data
);
  localparam int CW = hsc_pkg::CountWidth;
  logic [23:0] blue_lo_r, blue_hi_r, brt_lo_r, brt_hi_r;
  logic [16:0] thr_r, clr_r, dark_r;
  logic [7:0] period_r, phase_r;
  logic [CW-1:0] blue_cnt_r, brt_cnt_r;
  logic [36:0] out_r;
  logic out_vld_r, en;
  hsc_pkg::bgr_t pix;
  hsc_pkg::cell_t c0, c1, c2, seed;
  hsc_pkg::hit_t hit;
  logic [CW-1:0] bn, pn;
  logic [16:0] bt, pt;
  logic [1:0] cls;
  logic [7:0] ph_inc;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_r;
  assign pix = '{b: in_ch.data[24:17], g: in_ch.data[16:9], r: in_ch.data[8:1]};
  always_comb begin
    seed = '0;
    seed.vld = in_ch.valid;
    seed.last = in_ch.data[0];
  end

  hsc_cell u_c0 (.clk, .rst_n, .en, .step(2'd0), .pix, .prev(seed), .cur_r(c0));
  hsc_cell u_c1 (.clk, .rst_n, .en, .step(2'd1), .pix, .prev(c0), .cur_r(c1));
  hsc_cell u_c2 (.clk, .rst_n, .en, .step(2'd2), .pix, .prev(c1), .cur_r(c2));
  hsc_match u_m (.clk, .rst_n, .en, .prev(c2), .blue_lo(blue_lo_r), .blue_hi(blue_hi_r),
                 .brt_lo(brt_lo_r), .brt_hi(brt_hi_r), .hit_r(hit));

  always_comb begin
    bn = blue_cnt_r + CW'(hit.blue_hit && blue_cnt_r != {CW{1'b1}});
    pn = brt_cnt_r + CW'(hit.bright_hit && brt_cnt_r != {CW{1'b1}});
    bt = 17'(bn);
    pt = 17'(pn);
    if (bt >= clr_r || bt >= thr_r) cls = hsc_pkg::ClsClear;
    else if (bt >= pt || bt >= dark_r) cls = hsc_pkg::ClsPartly;
    else cls = hsc_pkg::ClsDark;
    ph_inc = phase_r + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_lo_r <= '0; blue_hi_r <= 24'hFFFFFF;
      brt_lo_r <= '0; brt_hi_r <= 24'hFFFFFF;
      thr_r <= 17'd15500; clr_r <= 17'd25600; dark_r <= 17'd5000;
      period_r <= 8'd50;
      blue_cnt_r <= '0; brt_cnt_r <= '0; phase_r <= '0; out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          hsc_pkg::RegBlueLow:    blue_lo_r <= cfg_data;
          hsc_pkg::RegBlueHigh:   blue_hi_r <= cfg_data;
          hsc_pkg::RegBrightLow:  brt_lo_r <= cfg_data;
          hsc_pkg::RegBrightHigh: brt_hi_r <= cfg_data;
          hsc_pkg::RegBlueThr:    thr_r <= cfg_data[16:0];
          hsc_pkg::RegClearLvl:   clr_r <= cfg_data[16:0];
          hsc_pkg::RegDarkLvl:    dark_r <= cfg_data[16:0];
          hsc_pkg::RegPeriod:     period_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_ch.ready) out_vld_r <= 1'b0;
      if (en && hit.vld) begin
        if (hit.last) begin
          blue_cnt_r <= '0; brt_cnt_r <= '0;
          phase_r <= (ph_inc >= period_r) ? 8'd0 : ph_inc;
          out_vld_r <= 1'b1;
          out_r <= {cls, bt, pt, phase_r == 8'd0};
        end else begin
          blue_cnt_r <= bn; brt_cnt_r <= pn;
        end
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_r))
    else $error("result dropped under stall");
  a_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r[36:35] != 2'd3)
    else $error("bad class code");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    en && hit.vld && hit.last |=> blue_cnt_r == '0 && brt_cnt_r == '0)
    else $error("counters not cleared at frame end");
endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for hsv_pixel_count_sky_classifier
// depends on hsc_pkg, hsc_stream_if and the classifier rtl
// predicts hsv conversion, box counts and frame classes, checks every result transaction
`timescale 1ns / 1ps

module tb;
  localparam int Limit = 3000000;
  localparam int CntMax = 131071;

  typedef struct packed {
    logic [1:0]  cls;
    logic [16:0] blue_total;
    logic [16:0] bright_total;
    logic        send_report;
  } frame_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [hsc_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [hsc_pkg::CfgDataW-1:0] cfg_data = '0;

  hsc_stream_if #(.W(25)) in_if (clk);
  hsc_stream_if #(.W(37)) out_if (clk);

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  hsv_pixel_count_sky_classifier uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [23:0] blue_lo, blue_hi, bright_lo, bright_hi;
  int blue_thr, clear_lvl, dark_lvl, period;
  int blue_cnt, bright_cnt, phase;
  frame_res_t frame_q[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int errors = 0;
  int cycles = 0;
  int n_pix = 0;
  int n_frames = 0;
  int n_checked = 0;

  function automatic logic [23:0] to_hsv(input int b, input int g, input int r);
    int v, mn, diff, s, hue, sf, hf, h;
    longint x;
    v = b; mn = b; s = 0; hue = 0;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    diff = v - mn;
    if (v != 0) begin
      sf = (2088960 + v) / (2 * v);
      s = (diff * sf + 2048) >>> 12;
    end
    if (diff != 0) begin
      hf = (245760 + diff) / (2 * diff);
      if (v == r) h = g - b;
      else if (v == g) h = b - r + 2 * diff;
      else h = r - g + 4 * diff;
      x = longint'(h) * hf + 2048 + (longint'(256) << 12);
      h = int'(x >>> 12) - 256;
      if (h < 0) h += 180;
      hue = h & 255;
    end
    return {hue[7:0], s[7:0], v[7:0]};
  endfunction

  function automatic bit in_box(input logic [23:0] p, input logic [23:0] lo,
                                input logic [23:0] hi);
    for (int k = 0; k < 3; k++) begin
      if (p[k*8 +: 8] < lo[k*8 +: 8] || p[k*8 +: 8] > hi[k*8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic count_pixel(input int b, input int g, input int r, input bit last);
    logic [23:0] p;
    frame_res_t fr;
    p = to_hsv(b, g, r);
    if (in_box(p, blue_lo, blue_hi) && blue_cnt < CntMax) blue_cnt++;
    if (in_box(p, bright_lo, bright_hi) && bright_cnt < CntMax) bright_cnt++;
    if (last) begin
      fr.blue_total = blue_cnt[16:0];
      fr.bright_total = bright_cnt[16:0];
      if (blue_cnt >= clear_lvl || blue_cnt >= blue_thr) fr.cls = hsc_pkg::ClsClear;
      else if (blue_cnt >= bright_cnt || blue_cnt >= dark_lvl) fr.cls = hsc_pkg::ClsPartly;
      else fr.cls = hsc_pkg::ClsDark;
      fr.send_report = (phase == 0);
      phase = (phase + 1) & 255;
      if (phase >= period) phase = 0;
      frame_q.push_back(fr);
      blue_cnt = 0;
      bright_cnt = 0;
      n_frames++;
    end
  endtask

  task automatic send_pixel(input int b, input int g, input int r, input bit last);
    if ($urandom_range(99) < gap_pct) begin
      repeat ($urandom_range(1, 3)) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid <= 1'b1;
    in_if.data <= {b[7:0], g[7:0], r[7:0], last};
    do @(posedge clk); while (!in_if.ready);
    count_pixel(b, g, r, last);
    n_pix++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    wait (frame_q.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hsc_pkg::CfgIdxW-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hsc_pkg::RegBlueLow: blue_lo = val[23:0];
      hsc_pkg::RegBlueHigh: blue_hi = val[23:0];
      hsc_pkg::RegBrightLow: bright_lo = val[23:0];
      hsc_pkg::RegBrightHigh: bright_hi = val[23:0];
      hsc_pkg::RegBlueThr: blue_thr = val & CntMax;
      hsc_pkg::RegClearLvl: clear_lvl = val & CntMax;
      hsc_pkg::RegDarkLvl: dark_lvl = val & CntMax;
      hsc_pkg::RegPeriod: period = val & 255;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_pixel(output int b, output int g, output int r);
    int kind;
    kind = $urandom_range(3);
    if (kind <= 1) begin
      b = $urandom_range(120, 255); g = $urandom_range(40, b); r = $urandom_range(0, g);
    end else if (kind == 2) begin
      b = $urandom_range(180, 255); g = $urandom_range(170, 255); r = $urandom_range(160, 255);
    end else begin
      b = $urandom_range(255); g = $urandom_range(255); r = $urandom_range(255);
    end
  endtask

  task automatic random_frame(input int max_len);
    int len, b, g, r;
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      random_pixel(b, g, r);
      send_pixel(b, g, r, i == len - 1);
    end
  endtask

  task automatic random_setup();
    int h;
    h = $urandom_range(70, 110);
    write_reg(hsc_pkg::RegBlueLow,
              {h[7:0], 8'($urandom_range(20, 90)), 8'($urandom_range(60, 150))});
    write_reg(hsc_pkg::RegBlueHigh,
              {8'(h + $urandom_range(10, 69)), 8'($urandom_range(150, 255)), 8'hff});
    write_reg(hsc_pkg::RegBrightLow, {8'h00, 8'h00, 8'($urandom_range(150, 220))});
    write_reg(hsc_pkg::RegBrightHigh, {8'hb3, 8'($urandom_range(20, 90)), 8'hff});
    write_reg(hsc_pkg::RegBlueThr, $urandom_range(0, 30));
    write_reg(hsc_pkg::RegClearLvl, $urandom_range(0, 40));
    write_reg(hsc_pkg::RegDarkLvl, $urandom_range(0, 20));
    write_reg(hsc_pkg::RegPeriod, ($urandom_range(7) == 0) ? 255 : $urandom_range(1, 6));
  endtask

  // receiver and result check
  always @(posedge clk) begin
    frame_res_t got, want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (frame_q.size() == 0) begin
          $error("result transaction with nothing expected: %h", got);
          errors++;
        end else begin
          want = frame_q.pop_front();
          n_checked++;
          if (got.cls !== want.cls) begin
            $error("sky_class expected %0d actual %0d", want.cls, got.cls); errors++;
          end
          if (got.blue_total !== want.blue_total) begin
            $error("blue_total expected %0d actual %0d", want.blue_total, got.blue_total);
            errors++;
          end
          if (got.bright_total !== want.bright_total) begin
            $error("bright_total expected %0d actual %0d", want.bright_total,
                   got.bright_total);
            errors++;
          end
          if (got.send_report !== want.send_report) begin
            $error("send_report expected %0d actual %0d", want.send_report,
                   got.send_report);
            errors++;
          end
        end
      end
      if (hold_len > 0) begin
        out_if.ready <= 1'b0;
        hold_len--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    write_reg(hsc_pkg::RegBlueLow, 24'h5a_3c_50);
    write_reg(hsc_pkg::RegBlueHigh, 24'h82_ff_ff);
    write_reg(hsc_pkg::RegBrightLow, 24'h00_00_b4);
    write_reg(hsc_pkg::RegBrightHigh, 24'hb3_3c_ff);
    write_reg(hsc_pkg::RegBlueThr, 4);
    write_reg(hsc_pkg::RegClearLvl, 6);
    write_reg(hsc_pkg::RegDarkLvl, 2);
    write_reg(hsc_pkg::RegPeriod, 3);
    // black, white, grey, primaries, sector ties
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 0);
    send_pixel(128, 128, 128, 0);
    send_pixel(255, 0, 0, 0);
    send_pixel(0, 255, 0, 0);
    send_pixel(0, 0, 255, 1);
    send_pixel(255, 0, 255, 0);
    send_pixel(0, 255, 255, 0);
    send_pixel(255, 255, 0, 0);
    send_pixel(1, 0, 0, 1);
    for (int i = 0; i < 5; i++) send_pixel(230, 150, 60, i == 4);
    send_pixel(240, 240, 250, 0);
    send_pixel(250, 245, 240, 0);
    send_pixel(235, 160, 70, 1);
    send_pixel(10, 20, 200, 1);
    for (int i = 0; i < 3; i++) send_pixel(240, 170, 80, i == 2);
    drain();
  endtask

  task automatic test_config_extremes();
    int vals[4] = '{0, 24'hffffff, 24'h010101, 24'hfefefe};
    for (int i = 0; i < 4; i++) begin
      write_reg(hsc_pkg::RegBlueLow, vals[i]);
      write_reg(hsc_pkg::RegBlueHigh, vals[3 - i]);
      write_reg(hsc_pkg::RegBrightLow, vals[(i + 1) % 4]);
      write_reg(hsc_pkg::RegBrightHigh, vals[(i + 2) % 4]);
      write_reg(hsc_pkg::RegBlueThr, (i % 2) ? CntMax : 0);
      write_reg(hsc_pkg::RegClearLvl, (i % 2) ? 0 : CntMax);
      write_reg(hsc_pkg::RegDarkLvl, (i == 2) ? 0 : CntMax);
      write_reg(hsc_pkg::RegPeriod, (i == 0) ? 0 : (i == 1) ? 255 : 1);
      for (int f = 0; f < 4; f++) random_frame(8);
      drain();
    end
    // period lowered below the current phase
    write_reg(hsc_pkg::RegPeriod, 200);
    for (int f = 0; f < 5; f++) random_frame(3);
    drain();
    write_reg(hsc_pkg::RegPeriod, 2);
    for (int f = 0; f < 4; f++) random_frame(3);
    drain();
  endtask

  task automatic test_random(input int gp, input int sp, input int n);
    int start;
    gap_pct = gp;
    stall_pct = sp;
    random_setup();
    start = n_pix;
    while (n_pix - start < n) random_frame(24);
    drain();
  endtask

  task automatic test_backpressure();
    stall_pct = 0;
    gap_pct = 0;
    @(posedge clk);
    hold_len = 300;
    for (int f = 0; f < 40; f++) random_frame(4);
    drain();
  endtask

  initial begin
    blue_lo = 0; blue_hi = 24'hffffff; bright_lo = 0; bright_hi = 24'hffffff;
    blue_thr = 15500; clear_lvl = 25600; dark_lvl = 5000; period = 50;
    blue_cnt = 0; bright_cnt = 0; phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // a few frames at reset defaults
    for (int f = 0; f < 3; f++) random_frame(6);
    drain();
    test_directed();
    test_config_extremes();
    test_random(0, 0, 280);
    test_random(47, 0, 280);
    test_random(0, 47, 280);
    test_random(22, 22, 280);
    test_backpressure();
    $display("covered %0d pixel transactions and %0d frames, %0d results checked",
             n_pix, n_frames, n_checked);
    $display("directed colors, register extremes, idle and stall mixes, long back-pressure run");
    if (errors == 0 && frame_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/hsc_pkg.sv
src/hsc_if.sv
src/hsc_cell.sv
src/hsc_match.sv
src/hsv_pixel_count_sky_classifier.sv
tb/tb.sv
